// ----- rtl/axss_pkg.sv -----
package axss_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_SEQ_ENABLE  = 2'd0;
  localparam logic [1:0] CFG_STEP_COUNT  = 2'd1;
  localparam logic [1:0] CFG_AXIS_OFFSET = 2'd2;

  // input command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  localparam logic [7:0] HELD_RESET = 8'd127;
  localparam logic [7:0] AXIS_MAX   = 8'd255;

  // result queue depth and its counter width
  localparam int unsigned OUT_DEPTH = 3;
  localparam int unsigned OUT_CW    = 2;

  typedef struct packed {
    logic [7:0] axis_value;
    logic       steps_done;
  } axss_res_t;

endpackage

// ----- rtl/axss_ram.sv -----
module axss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/axss_core.sv -----
module axss_core #(
  parameter int unsigned PCB   = 32,
  parameter int unsigned IDX_W = 5,
  parameter int unsigned AW    = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 seq_enable_i,
  input  logic [IDX_W-1:0]     n_active_i,
  input  logic signed [7:0]    axis_offset_i,
  input  logic                 poll_i,
  input  logic [7:0]           real_value_i,
  input  logic [7:0]           rd_axis_i,
  input  logic [PCB-1:0]       rd_polls_i,
  output logic [AW-1:0]        ram_raddr_o,
  output logic                 busy_o,
  output logic                 push_o,
  output axss_pkg::axss_res_t  res_o
);
  import axss_pkg::*;

  logic             s1_valid_q;
  logic [7:0]       s1_real_q;
  logic [IDX_W-1:0] step_index_q, step_index_d;
  logic [PCB-1:0]   polls_in_step_q, polls_in_step_d;
  logic [7:0]       held_axis_q, held_axis_d;

  logic             running;
  logic [PCB:0]     limit;
  logic [PCB:0]     inc;
  logic             advance;
  logic signed [9:0] sum;
  logic [7:0]       off_val;

  assign running = seq_enable_i && (step_index_q < n_active_i);
  // a count of zero lasts one poll
  assign limit   = (rd_polls_i == '0) ? (PCB+1)'(1) : {1'b0, rd_polls_i};
  assign inc     = {1'b0, polls_in_step_q} + (PCB+1)'(1);
  assign advance = inc >= limit;

  always_comb begin
    step_index_d    = step_index_q;
    polls_in_step_d = polls_in_step_q;
    held_axis_d     = held_axis_q;
    if (s1_valid_q && running) begin
      if (advance) begin
        step_index_d    = step_index_q + IDX_W'(1);
        polls_in_step_d = '0;
        held_axis_d     = rd_axis_i;
      end else begin
        polls_in_step_d = inc[PCB-1:0];
      end
    end
  end

  // next poll reads the entry for the index this poll leaves behind
  assign ram_raddr_o = step_index_d[AW-1:0];

  assign sum = $signed({2'b00, s1_real_q}) + $signed({{2{axis_offset_i[7]}}, axis_offset_i});

  always_comb begin
    if (sum < 0) begin
      off_val = '0;
    end else if (sum > 10'sd255) begin
      off_val = AXIS_MAX;
    end else begin
      off_val = sum[7:0];
    end
  end

  always_comb begin
    if (running) begin
      res_o.axis_value = rd_axis_i;
    end else if (seq_enable_i) begin
      res_o.axis_value = held_axis_q;
    end else begin
      res_o.axis_value = off_val;
    end
    res_o.steps_done = step_index_d >= n_active_i;
  end

  assign push_o = s1_valid_q;
  assign busy_o = s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q      <= 1'b0;
      step_index_q    <= '0;
      polls_in_step_q <= '0;
      held_axis_q     <= HELD_RESET;
    end else begin
      s1_valid_q      <= poll_i;
      step_index_q    <= step_index_d;
      polls_in_step_q <= polls_in_step_d;
      held_axis_q     <= held_axis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poll_i) begin
      s1_real_q <= real_value_i;
    end
  end

endmodule

// ----- rtl/axss_out_fifo.sv -----
module axss_out_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  axss_pkg::axss_res_t          data_i,
  input  logic                         pop_i,
  output logic                         valid_o,
  output axss_pkg::axss_res_t          data_o,
  output logic [axss_pkg::OUT_CW-1:0]  count_o
);
  import axss_pkg::*;

  localparam logic [OUT_CW-1:0] LAST = OUT_CW'(OUT_DEPTH - 1);

  axss_res_t         buf_q [OUT_DEPTH];
  logic [OUT_CW-1:0] wr_ptr_q, rd_ptr_q, count_q;
  logic              do_pop;

  assign do_pop  = pop_i && (count_q != '0);
  assign valid_o = count_q != '0;
  assign data_o  = buf_q[rd_ptr_q];
  assign count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + OUT_CW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + OUT_CW'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + OUT_CW'(1);
      end else if (!push_i && do_pop) begin
        count_q <= count_q - OUT_CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/axis_step_sequencer_with_offset.sv -----
// Axis step sequencer with offset.
// Input channel (in_valid_i / in_stall_o) carries one beat per load or poll.
// A load (cmd_i = 0) writes entry_index_i of the step table and gives no
// result; a poll (cmd_i = 1) gives exactly one result beat on the output
// channel (out_valid_o / out_stall_i): the forced step value while the
// sequence runs, the held value once it has finished, or the real byte plus
// the signed offset, clamped to 0..255, when the sequence is disabled.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_index_i
// (0 seq_enable, 1 step_count, 2 axis_offset); write only while idle.
// Throughput: one beat per cycle while in_stall_o is low, loads and polls
// mixed freely. A poll's result passes through registers in order: the step table RAM
// read is registered, then the step counter compare and update run in one
// stage that writes the result queue.
// Back-pressure: results wait in a three-entry queue; in_stall_o rises only
// when the queue plus the beat in flight would fill it.
// Reset clears the sequence to step 0 with held value 127 and empties the
// queue; the step table is not cleared and must be loaded before use.
module axis_step_sequencer_with_offset #(
  parameter int unsigned MAX_STEPS       = 16,
  parameter int unsigned POLL_COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [3:0]  entry_index_i,
  input  logic [7:0]  entry_axis_i,
  input  logic [31:0] entry_polls_i,
  input  logic [7:0]  real_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  axis_value_o,
  output logic        steps_done_o
);
  import axss_pkg::*;

  localparam int unsigned PCB   = POLL_COUNT_BITS;
  localparam int unsigned IDX_W = $clog2(MAX_STEPS + 1);
  localparam int unsigned AW    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int unsigned CW    = (IDX_W > 5) ? IDX_W : 5;
  localparam int unsigned DW    = 8 + PCB;

  logic              seq_enable_q;
  logic [4:0]        step_count_q;
  logic signed [7:0] axis_offset_q;

  logic              in_acc, poll, load;
  logic [IDX_W-1:0]  n_active;
  logic [PCB-1:0]    polls_sat;
  logic              wr_ok;
  logic [AW-1:0]     raddr;
  logic [DW-1:0]     rdata;
  logic              busy, push;
  axss_res_t         res, out_res;
  logic [OUT_CW-1:0] q_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_enable_q  <= 1'b0;
      step_count_q  <= '0;
      axis_offset_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SEQ_ENABLE:  seq_enable_q  <= cfg_wdata_i[0];
        CFG_STEP_COUNT:  step_count_q  <= cfg_wdata_i[4:0];
        CFG_AXIS_OFFSET: axis_offset_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign n_active = (CW'(step_count_q) > CW'(MAX_STEPS)) ? IDX_W'(MAX_STEPS)
                                                         : IDX_W'(step_count_q);

  // stall once the queue plus the stage in flight would fill it
  assign in_stall_o = ({1'b0, q_count} + (OUT_CW+1)'(busy)) >= (OUT_CW+1)'(OUT_DEPTH);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign poll       = in_acc && (cmd_i == CMD_POLL);
  assign load       = in_acc && (cmd_i == CMD_LOAD);

  assign wr_ok = 9'(entry_index_i) < 9'(MAX_STEPS);

  generate
    if (PCB >= 32) begin : g_wide
      assign polls_sat = PCB'(entry_polls_i);
    end else begin : g_narrow
      assign polls_sat = (entry_polls_i[31:PCB] != '0) ? '1 : entry_polls_i[PCB-1:0];
    end
  endgenerate

  axss_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_STEPS),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (load && wr_ok),
    .waddr_i (AW'(entry_index_i)),
    .wdata_i ({entry_axis_i, polls_sat}),
    .re_i    (poll),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  axss_core #(
    .PCB   (PCB),
    .IDX_W (IDX_W),
    .AW    (AW)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seq_enable_i  (seq_enable_q),
    .n_active_i    (n_active),
    .axis_offset_i (axis_offset_q),
    .poll_i        (poll),
    .real_value_i  (real_value_i),
    .rd_axis_i     (rdata[DW-1:PCB]),
    .rd_polls_i    (rdata[PCB-1:0]),
    .ram_raddr_o   (raddr),
    .busy_o        (busy),
    .push_o        (push),
    .res_o         (res)
  );

  axss_out_fifo u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .pop_i   (!out_stall_i),
    .valid_o (out_valid_o),
    .data_o  (out_res),
    .count_o (q_count)
  );

  assign axis_value_o = out_res.axis_value;
  assign steps_done_o = out_res.steps_done;

endmodule

// ----- rtl/axss_checker.sv -----
module axss_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       cmd_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] axis_value_o,
  input logic       steps_done_o
);
  import axss_pkg::*;

  logic poll_acc;
  assign poll_acc = in_valid_i && !in_stall_o && (cmd_i == CMD_POLL);

  a_reset_empty: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("result beat straight after reset");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(axis_value_o) && $stable(steps_done_o))
    else $error("stalled result beat changed");

  a_result_from_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(poll_acc, 2))
    else $error("result beat without a poll two cycles earlier");

  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with no result pending");

endmodule

bind axis_step_sequencer_with_offset axss_checker u_axss_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .cmd_i        (cmd_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .axis_value_o (axis_value_o),
  .steps_done_o (steps_done_o)
);

// ----- bench/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import axss_pkg::*;

  localparam logic [1:0]  CFG_SPARE   = 2'd3;  // no register behind this index
  localparam int unsigned N_STEPS     = 16;
  localparam int unsigned PHASE_BEATS = 192;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // Tracks the step table, the sequence position and the offset setting, and
  // holds the results still owed by the block, oldest first.
  class axis_seq_tracker;
    bit                 seq_en;
    logic [4:0]         step_cnt;
    logic signed [7:0]  offset;
    logic [7:0]         tab_axis  [N_STEPS];
    logic [31:0]        tab_polls [N_STEPS];
    logic [4:0]         step_idx;
    logic [31:0]        polls_in;
    logic [7:0]         held;
    axss_res_t          due[$];
    int unsigned        fails;

    function new();
      seq_en   = 1'b0;
      step_cnt = '0;
      offset   = '0;
      step_idx = '0;
      polls_in = '0;
      held     = HELD_RESET;
      fails    = 0;
      foreach (tab_axis[i]) begin
        tab_axis[i]  = '0;
        tab_polls[i] = '0;
      end
    endfunction

    function void configure(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CFG_SEQ_ENABLE:  seq_en   = val[0];
        CFG_STEP_COUNT:  step_cnt = val[4:0];
        CFG_AXIS_OFFSET: offset   = val;
        default: ;
      endcase
    endfunction

    function logic [4:0] live_steps();
      return (step_cnt > N_STEPS) ? 5'(N_STEPS) : step_cnt;
    endfunction

    function logic [7:0] next_seq();
      logic [7:0]  val;
      logic [32:0] lim;
      if (step_idx >= live_steps()) return held;
      val = tab_axis[step_idx];
      lim = {1'b0, tab_polls[step_idx]};
      if (lim == 0) lim = 33'd1;  // zero count lasts one poll
      if ({1'b0, polls_in} + 33'd1 >= lim) begin
        polls_in = '0;
        held     = val;
        step_idx = step_idx + 5'd1;
      end else begin
        polls_in = polls_in + 32'd1;
      end
      return val;
    endfunction

    function logic [7:0] offset_byte(logic [7:0] raw);
      int sum;
      if (offset == 0) return raw;
      sum = int'(raw) + int'(offset);
      if (sum < 0) sum = 0;
      if (sum > 255) sum = 255;
      return 8'(sum);
    endfunction

    function void take_beat(logic c, logic [3:0] idx, logic [7:0] ax, logic [31:0] np,
                            logic [7:0] raw);
      axss_res_t r;
      if (c == CMD_LOAD) begin
        tab_axis[idx]  = ax;
        tab_polls[idx] = np;
        return;
      end
      r.axis_value = seq_en ? next_seq() : offset_byte(raw);
      r.steps_done = (step_idx >= live_steps());
      due = {due, r};
    endfunction

    task report(string msg);
      $display("%0t  %s", $time, msg);
      fails++;
    endtask

    task match_result(logic [7:0] av, logic dn);
      axss_res_t w;
      if (due.size() == 0) begin
        report($sformatf("result beat with nothing pending: axis_value=%0d steps_done=%0b",
                         av, dn));
        return;
      end
      w = due.pop_front();
      if (av !== w.axis_value)
        report($sformatf("axis_value got %0d, want %0d", av, w.axis_value));
      if (dn !== w.steps_done)
        report($sformatf("steps_done got %0b, want %0b", dn, w.steps_done));
    endtask
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_we      = 1'b0;
  logic [1:0]  cfg_index   = '0;
  logic [7:0]  cfg_wdata   = '0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic        cmd         = CMD_LOAD;
  logic [3:0]  entry_index = '0;
  logic [7:0]  entry_axis  = '0;
  logic [31:0] entry_polls = '0;
  logic [7:0]  real_value  = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [7:0]  axis_value;
  logic        steps_done;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int          hold_cycles = 0;

  axis_seq_tracker tracker;

  axis_step_sequencer_with_offset u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .cmd_i         (cmd),
    .entry_index_i (entry_index),
    .entry_axis_i  (entry_axis),
    .entry_polls_i (entry_polls),
    .real_value_i  (real_value),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .axis_value_o  (axis_value),
    .steps_done_o  (steps_done)
  );

  always #5 clk = ~clk;

  // receiver: random stalls, or one long hold-off when asked for
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.match_result(axis_value, steps_done);
  end

  task automatic send_beat(logic c, logic [3:0] idx, logic [7:0] ax, logic [31:0] np,
                           logic [7:0] rv);
    @(negedge clk);
    // the sender keeps offering throughout a hold-off so the block fills up
    while (hold_cycles == 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c;
    entry_index <= idx;
    entry_axis  <= ax;
    entry_polls <= np;
    real_value  <= rv;
    do @(posedge clk); while (in_stall);
    tracker.take_beat(c, idx, ax, np, rv);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.due.size() != 0) @(negedge clk);
    // a trailing load may still be in the pipe
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [7:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    tracker.configure(idx, d);
  endtask

  task automatic set_config(bit en, logic [4:0] cnt, logic [7:0] off);
    wait_idle();
    cfg_write(CFG_SEQ_ENABLE, {7'($urandom), en});
    cfg_write(CFG_STEP_COUNT, {3'($urandom), cnt});
    cfg_write(CFG_AXIS_OFFSET, off);
    cfg_write(CFG_SPARE, 8'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    logic        c;
    logic [3:0]  idx;
    logic [7:0]  ax;
    logic [7:0]  rv;
    logic [31:0] np;
    tracker = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: zero offset passes the byte through, empty sequence is done
    send_beat(CMD_POLL, 4'd0, 8'h00, 32'h0, 8'h00);
    send_beat(CMD_POLL, 4'd15, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    // huge count first, then overwritten below; every slot loaded before use
    send_beat(CMD_LOAD, 4'd15, 8'hFF, 32'hFFFF_FFFF, 8'h00);
    for (int i = 0; i < N_STEPS; i++) begin
      ax = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom);
      np = (i < 3) ? 32'(i) : 32'($urandom_range(0, 4));
      send_beat(CMD_LOAD, 4'(i), ax, np, 8'($urandom));
    end
    set_config(1'b0, 5'd0, 8'h7F);
    send_beat(CMD_POLL, 4'd0, 8'h00, 32'h0, 8'd200);
    send_beat(CMD_POLL, 4'd0, 8'h00, 32'h0, 8'd0);
    set_config(1'b0, 5'd0, 8'h80);
    send_beat(CMD_POLL, 4'd0, 8'h00, 32'h0, 8'd5);
    send_beat(CMD_POLL, 4'd0, 8'h00, 32'h0, 8'd255);
    // sequence on with no steps: held value straight away
    set_config(1'b1, 5'd0, 8'h00);
    send_beat(CMD_POLL, 4'd0, 8'h00, 32'h0, 8'($urandom));

    for (int p = 0; p < 9; p++) begin
      case (p / 3)
        0: begin tx_idle_pct = 7;  rx_idle_pct = 62; end
        1: begin tx_idle_pct = 62; rx_idle_pct = 7;  end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      // step count only ever steps the sequence on; the dip to 4 ends it early
      case (p)
        0: set_config(1'b1, 5'd2,  8'h00);
        1: set_config(1'b0, 5'd2,  8'h7F);
        2: set_config(1'b1, 5'd6,  8'h81);
        3: set_config(1'b0, 5'd6,  8'h80);
        4: set_config(1'b0, 5'd10, 8'($urandom));
        5: set_config(1'b1, 5'd4,  8'hFF);
        6: set_config(1'b1, 5'd16, 8'h00);
        7: set_config(1'b0, 5'd31, 8'h01);
        default: set_config(1'b1, 5'd20, 8'hFF);
      endcase
      if (p % 3 == 1) begin
        @(posedge clk);
        hold_cycles = 150;
      end
      repeat (PHASE_BEATS) begin
        c   = ($urandom_range(0, 99) < 65) ? CMD_POLL : CMD_LOAD;
        idx = 4'($urandom_range(0, 15));
        ax  = 8'($urandom);
        rv  = 8'($urandom);
        // steps still ahead get short counts so the sequence keeps moving
        if (c == CMD_POLL || {1'b0, idx} < tracker.step_idx) np = $urandom;
        else np = 32'($urandom_range(0, 9));
        send_beat(c, idx, ax, np, rv);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (tracker.fails == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/axss_pkg.sv
rtl/axss_ram.sv
rtl/axss_core.sv
rtl/axss_out_fifo.sv
rtl/axis_step_sequencer_with_offset.sv
rtl/axss_checker.sv
bench/testbench.sv
